// File: hdl/firfc_pkg.sv
`default_nettype none

package firfc_pkg;

  // Default filter length.
  localparam int TAPS_DEF = 25;

  // Field widths.
  localparam int SAMP_W = 16;
  localparam int IDX_W  = 5;
  localparam int PROD_W = 2 * SAMP_W;
  localparam int OUT_W  = 36;

  // Item kind codes.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  // One input item.
  typedef struct packed {
    logic                     kind;
    logic signed [SAMP_W-1:0] sample;
    logic                     last_sample;
    logic [IDX_W-1:0]         coef_index;
    logic signed [SAMP_W-1:0] coef_value;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic signed [OUT_W-1:0] filtered;
    logic                    last;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate unit.
  typedef struct packed {
    logic start;  // clear the accumulator and the product pipeline
    logic mul;    // mark this cycle's product for accumulation
  } mac_ctl_t;

endpackage

`default_nettype wire

// File: hdl/firfc_mac.sv
`default_nettype none

module firfc_mac
  import firfc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire mac_ctl_t                 ctl,
  input  wire logic signed [SAMP_W-1:0] coef,
  input  wire logic signed [SAMP_W-1:0] samp,
  output      logic signed [OUT_W-1:0]  acc
);

  logic signed [PROD_W-1:0] prod_r;
  logic                     pv_r;
  logic signed [OUT_W-1:0]  acc_r;

  // Product register; the accumulator adds it in the following cycle.
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(coef) * PROD_W'(samp);
  end

  // Product-valid flag is the multiply request, registered.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (ctl.start) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.mul;
    end
  end

  // Full-precision accumulator; it wraps modulo 2^OUT_W.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      acc_r <= '0;
    end else if (pv_r) begin
      acc_r <= acc_r + {{(OUT_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign acc = acc_r;

endmodule

`default_nettype wire

// File: hdl/fir_filter_full_convolution.sv
// Direct-form FIR filter of TAPS taps (1 to 32) with Q1.15 samples and
// coefficients and a 36-bit Q6.30 accumulator. A coefficient write gives no
// result; indexes at or above TAPS are ignored, and every tap must be written
// before the first sample. A sample item gives one result: it is accepted,
// the delay line shifts, TAPS products go through the single shared 16x16
// multiplier, the last product is added and the output register is loaded,
// which waits while an earlier result is still untaken. A sample marked last
// then gives TAPS-1 more results, each from the shift on, with zeros shifted
// in; the final one carries last, and the delay line starts from zero for the
// next block. The input is not ready while an item is in work, and the output
// register lets the next item be accepted while a result waits to be taken.
`default_nettype none

module fir_filter_full_convolution
  import firfc_pkg::*;
#(
  parameter int TAPS = TAPS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_ready,
  input  wire in_item_t  in_item,
  output      logic      out_valid,
  input  wire logic      out_ready,
  output      out_item_t out_item
);

  localparam int AW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int XW = 7;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_MAC   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [AW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            flush_r, flush_nxt;
  logic                     last_blk_r, last_blk_nxt;
  logic signed [SAMP_W-1:0] x_r, x_nxt;
  logic signed [SAMP_W-1:0] win_r [TAPS];
  logic signed [SAMP_W-1:0] coef_mem [TAPS];
  logic signed [SAMP_W-1:0] coef_rd_r;
  logic [AW-1:0]            rd_addr;
  logic [XW-1:0]            idx_ext;
  logic                     in_acc;
  logic                     coef_we;
  logic                     emit;
  logic                     out_valid_r;
  out_item_t                out_item_r;
  mac_ctl_t                 mac_ctl;
  logic signed [OUT_W-1:0]  acc;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign idx_ext  = {{(XW-IDX_W){1'b0}}, in_item.coef_index};
  assign coef_we  = in_acc && (in_item.kind == KIND_COEF) && (idx_ext < XW'(TAPS));
  assign emit     = (state_r == S_OUT) && (!out_valid_r || out_ready);

  // Coefficient memory: one write port from the input, one registered read.
  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[idx_ext[AW-1:0]] <= in_item.coef_value;
    end
    coef_rd_r <= coef_mem[rd_addr];
  end

  // Read address runs one tap ahead of the multiplier.
  always_comb begin
    rd_addr = '0;
    if (state_r == S_MAC && cnt_r != AW'(TAPS - 1)) begin
      rd_addr = AW'(cnt_r + 1'b1);
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    flush_nxt    = flush_r;
    last_blk_nxt = last_blk_r;
    x_nxt        = x_r;
    mac_ctl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_acc && in_item.kind == KIND_SAMPLE) begin
          x_nxt        = in_item.sample;
          last_blk_nxt = in_item.last_sample;
          flush_nxt    = in_item.last_sample ? AW'(TAPS - 1) : '0;
          state_nxt    = S_SHIFT;
        end
      end
      S_SHIFT: begin
        mac_ctl.start = 1'b1;
        cnt_nxt       = '0;
        state_nxt     = S_MAC;
      end
      S_MAC: begin
        mac_ctl.mul = 1'b1;
        cnt_nxt     = AW'(cnt_r + 1'b1);
        if (cnt_r == AW'(TAPS - 1)) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (emit) begin
          if (last_blk_r && flush_r != '0) begin
            flush_nxt = AW'(flush_r - 1'b1);
            x_nxt     = '0;
            state_nxt = S_SHIFT;
          end else begin
            last_blk_nxt = 1'b0;
            state_nxt    = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      flush_r    <= '0;
      last_blk_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      flush_r    <= flush_nxt;
      last_blk_r <= last_blk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

  // Tap window: shifts in a sample, rotates once per tap during the sum, and
  // clears after the last result of a block.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
    end else if (state_r == S_SHIFT) begin
      for (int i = TAPS - 1; i > 0; i--) begin
        win_r[i] <= win_r[i-1];
      end
      win_r[0] <= x_r;
    end else if (state_r == S_MAC) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        win_r[i] <= win_r[i+1];
      end
      win_r[TAPS-1] <= win_r[0];
    end else if (emit && last_blk_r && flush_r == '0) begin
      for (int i = 0; i < TAPS; i++) begin
        win_r[i] <= '0;
      end
    end
  end

  firfc_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .coef  (coef_rd_r),
    .samp  (win_r[0]),
    .acc   (acc)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.filtered <= acc;
      out_item_r.last     <= last_blk_r && (flush_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // A tail count is only owed inside a block that ends.
  a_flush_in_block: assert property (@(posedge clk) disable iff (!rst_n)
    (flush_r != '0) |-> last_blk_r)
    else $error("tail count set outside a last block");

  // Between items no tail is pending.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!last_blk_r && flush_r == '0))
    else $error("idle with a pending tail");

  // The tap counter stays within the filter length.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MAC) |-> (cnt_r <= AW'(TAPS - 1)))
    else $error("tap counter out of range");

  // The drain state is always followed by the output state.
  a_mac_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DRAIN) |=> (state_r == S_OUT))
    else $error("drain not followed by output");

endmodule

`default_nettype wire
